[rtl/tbt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbt_pkg: shared types and constants
// Configuration bundle, register indexes, command codes and small helpers
// used by the tiled Bernsen threshold block.
// ----------------------------------------------------------------------------
package tbt_pkg;

  localparam int IMG_W  = 12;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_TILES_ACROSS   = 3'd2;
  localparam logic [2:0] REG_TILES_DOWN     = 3'd3;
  localparam logic [2:0] REG_CONTRAST_LIMIT = 3'd4;

  localparam logic CMD_GATHER    = 1'b0;
  localparam logic CMD_THRESHOLD = 1'b1;

  // One store lane: max in the upper byte, min in the lower byte.
  localparam logic [15:0] LANE_RESET = 16'h00FF;

  typedef struct packed {
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [4:0]  tiles_across;
    logic [4:0]  tiles_down;
    logic [7:0]  contrast_limit;
  } tbt_cfg_t;

  // Effective tile count: zero acts as one, values above the limit saturate.
  function automatic logic [6:0] eff_tiles(input logic [4:0] t, input logic [6:0] lim);
    logic [6:0] r;
    r = {2'b00, t};
    if (t == 5'd0) r = 7'd1;
    else if ({2'b00, t} > lim) r = lim;
    return r;
  endfunction

  // Dividend whose quotient by the extent gives the subtile of position p.
  function automatic logic [19:0] part_num(input logic [10:0] p, input logic [7:0] n);
    logic [19:0] r;
    r = 20'(20'({1'b0, p} + 12'd1) * 20'(n)) - 20'd1;
    return r;
  endfunction

endpackage

[rtl/tbt_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbt_div: shared restoring divider
// One quotient bit per cycle; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
module tbt_div #(
  parameter int NW = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [NW-1:0]              num,
  input  logic [tbt_pkg::IMG_W-1:0]  den,
  output logic                       done,
  output logic [NW-1:0]              quo
);
  import tbt_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [IMG_W-1:0]  rem_r;
  logic [IMG_W-1:0]  den_r;
  logic [NW-1:0]     quo_r;
  logic [IMG_W:0]    trial;
  logic              ge;
  logic [IMG_W-1:0]  rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[NW-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? IMG_W'(trial - {1'b0, den_r}) : trial[IMG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[rtl/tbt_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbt_queue: small FIFO between front and back
// Two entries of decoded work; push and pop are independent.
// ----------------------------------------------------------------------------
module tbt_queue #(
  parameter int W = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  logic [W-1:0] ent_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      case ({push && !full, pop && !empty})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) ent_r[wp_r] <= wdata;
  end

endmodule

[rtl/tbt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbt_front: input word decode
// Accepts words, finds the subtile (gather) or tile (threshold) with the
// shared divider and pushes the decoded work into the queue.
// ----------------------------------------------------------------------------
module tbt_front #(
  parameter int MAX_TILES_X = 16,
  parameter int MAX_TILES_Y = 16,
  parameter int SXW         = 5,
  parameter int SYW         = 5,
  parameter int QW          = 22
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tbt_pkg::tbt_cfg_t cfg,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,
  input  logic [1:0]       in_tuser,
  output logic             q_push,
  output logic [QW-1:0]    q_data,
  input  logic             q_full
);
  import tbt_pkg::*;

  localparam int GXW = $clog2(2 * MAX_TILES_X + 1);
  localparam int GYW = $clog2(2 * MAX_TILES_Y + 1);
  localparam int GMW = (GXW > GYW) ? GXW : GYW;
  localparam int NW  = IMG_W + GMW;

  localparam logic [3:0] F_IDLE = 4'd0;
  localparam logic [3:0] F_G1   = 4'd1;
  localparam logic [3:0] F_G2   = 4'd2;
  localparam logic [3:0] F_T1   = 4'd3;
  localparam logic [3:0] F_T2   = 4'd4;
  localparam logic [3:0] F_T3   = 4'd5;
  localparam logic [3:0] F_T4   = 4'd6;
  localparam logic [3:0] F_T5   = 4'd7;
  localparam logic [3:0] F_PUSH = 4'd8;

  logic [3:0]       st_r, st_nxt;
  logic             cmd_r, fs_r, upd_r, pass_r;
  logic [7:0]       pix_r;
  logic [10:0]      col_r, row_r;
  logic [IMG_W-1:0] tw_r, th_r;
  logic [SXW-1:0]   a_r;
  logic [SYW-1:0]   b_r;

  logic [6:0]       tx_n, ty_n;
  logic [7:0]       gx, gy;
  logic [7:0]       in_pix;
  logic [10:0]      in_col, in_row;
  logic             in_cmd, in_fs, in_img, pass;
  logic             div_start, div_done;
  logic [NW-1:0]    div_num, div_quo;
  logic [IMG_W-1:0] div_den;

  assign tx_n   = eff_tiles(cfg.tiles_across, 7'(MAX_TILES_X));
  assign ty_n   = eff_tiles(cfg.tiles_down, 7'(MAX_TILES_Y));
  assign gx     = {tx_n, 1'b0};
  assign gy     = {ty_n, 1'b0};
  assign in_pix = in_tdata[7:0];
  assign in_col = in_tdata[18:8];
  assign in_row = in_tdata[29:19];
  assign in_cmd = in_tuser[0];
  assign in_fs  = in_tuser[1];
  assign in_img = ({1'b0, in_col} < cfg.image_width) && ({1'b0, in_row} < cfg.image_height);
  assign pass   = (tw_r == '0) || (th_r == '0) ||
                  (19'(col_r) >= 19'(tw_r) * 19'(tx_n)) ||
                  (19'(row_r) >= 19'(th_r) * 19'(ty_n));

  tbt_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    st_nxt    = st_r;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (st_r)
      F_IDLE: begin
        if (in_tvalid) begin
          if (in_cmd == CMD_GATHER) begin
            if (in_img) begin
              div_start = 1'b1;
              div_num   = NW'(part_num(in_col, gx));
              div_den   = cfg.image_width;
              st_nxt    = F_G1;
            end else begin
              st_nxt = F_PUSH;
            end
          end else begin
            div_start = 1'b1;
            div_num   = NW'(cfg.image_width);
            div_den   = IMG_W'(tx_n);
            st_nxt    = F_T1;
          end
        end
      end
      F_G1: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = NW'(part_num(row_r, gy));
          div_den   = cfg.image_height;
          st_nxt    = F_G2;
        end
      end
      F_G2: if (div_done) st_nxt = F_PUSH;
      F_T1: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = NW'(cfg.image_height);
          div_den   = IMG_W'(ty_n);
          st_nxt    = F_T2;
        end
      end
      F_T2: if (div_done) st_nxt = F_T3;
      F_T3: begin
        if (pass) begin
          st_nxt = F_PUSH;
        end else begin
          div_start = 1'b1;
          div_num   = NW'(col_r);
          div_den   = tw_r;
          st_nxt    = F_T4;
        end
      end
      F_T4: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = NW'(row_r);
          div_den   = th_r;
          st_nxt    = F_T5;
        end
      end
      F_T5: if (div_done) st_nxt = F_PUSH;
      F_PUSH: if (!q_full) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= F_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      F_IDLE: begin
        if (in_tvalid) begin
          cmd_r  <= in_cmd;
          fs_r   <= in_fs;
          pix_r  <= in_pix;
          col_r  <= in_col;
          row_r  <= in_row;
          upd_r  <= in_img;
          pass_r <= 1'b0;
        end
      end
      F_G1: if (div_done) a_r <= SXW'(div_quo);
      F_G2: if (div_done) b_r <= SYW'(div_quo);
      F_T1: if (div_done) tw_r <= IMG_W'(div_quo);
      F_T2: if (div_done) th_r <= IMG_W'(div_quo);
      F_T3: pass_r <= pass;
      F_T4: if (div_done) a_r <= SXW'(div_quo);
      F_T5: if (div_done) b_r <= SYW'(div_quo);
      default: ;
    endcase
  end

  assign in_tready = st_r == F_IDLE;
  assign q_push    = (st_r == F_PUSH) && !q_full;
  assign q_data    = {cmd_r, upd_r && (cmd_r == CMD_GATHER),
                      fs_r && (cmd_r == CMD_GATHER), pass_r, pix_r, a_r, b_r};

endmodule

[rtl/tbt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbt_back: statistics store and threshold engine
// Folds gather pixels into the subtile min/max memory, scans the
// neighborhood for threshold pixels and holds the output register.
// ----------------------------------------------------------------------------
module tbt_back #(
  parameter int MAX_TILES_X = 16,
  parameter int MAX_TILES_Y = 16,
  parameter int SXW         = 5,
  parameter int SYW         = 5,
  parameter int QW          = 22
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tbt_pkg::tbt_cfg_t cfg,
  input  logic [QW-1:0]     q_data,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata
);
  import tbt_pkg::*;

  localparam int GXW    = $clog2(2 * MAX_TILES_X + 1);
  localparam int GYW    = $clog2(2 * MAX_TILES_Y + 1);
  localparam int GXW1   = GXW + 1;
  localparam int GYW1   = GYW + 1;
  localparam int DEPTH  = 4 * MAX_TILES_X * MAX_TILES_Y;
  localparam int GROUPS = MAX_TILES_X * MAX_TILES_Y;
  localparam int IW     = $clog2(DEPTH);
  localparam int GAW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_GRD  = 3'd1;
  localparam logic [2:0] B_GWR  = 3'd2;
  localparam logic [2:0] B_TINI = 3'd3;
  localparam logic [2:0] B_TRD  = 3'd4;
  localparam logic [2:0] B_TACC = 3'd5;
  localparam logic [2:0] B_TFIN = 3'd6;
  localparam logic [2:0] B_RES  = 3'd7;

  logic [63:0]       mem [GROUPS];
  logic [63:0]       rdata_r;
  logic [GROUPS-1:0] valid_r;

  logic [2:0]        st_r, st_nxt;
  logic [QW-1:0]     ent_r;
  logic [GAW-1:0]    gaddr_r;
  logic [1:0]        lane_r;
  logic [GXW-1:0]    j_r, x0_r, x1_r;
  logic [GYW-1:0]    i_r, y1_r;
  logic [7:0]        mn_r, mx_r, res_r;
  logic              out_tvalid_r;
  logic [7:0]        out_tdata_r;

  logic [7:0]        e_pix;
  logic [SXW-1:0]    e_a;
  logic [SYW-1:0]    e_b;
  logic [GXW-1:0]    gx;
  logic [GYW-1:0]    gy;
  logic [IW-1:0]     g_idx, s_idx;
  logic              rd_en;
  logic [GAW-1:0]    raddr;
  logic [63:0]       base, wword;
  logic [15:0]       lane_v;
  logic [7:0]        l_min, l_max;
  logic [GXW1-1:0]   x1t;
  logic [GYW1-1:0]   y1t;
  logic [GXW-1:0]    x0c;
  logic [GYW-1:0]    y0c;
  logic [7:0]        thr;

  assign gx = GXW'({eff_tiles(cfg.tiles_across, 7'(MAX_TILES_X)), 1'b0});
  assign gy = GYW'({eff_tiles(cfg.tiles_down, 7'(MAX_TILES_Y)), 1'b0});

  // Entry layout, high to low: command, update, clear, pass, pixel, x, y.
  assign e_pix  = ent_r[QW-5 -: 8];
  assign e_a    = ent_r[SXW+SYW-1:SYW];
  assign e_b    = ent_r[SYW-1:0];

  assign g_idx = IW'(IW'(e_b) * IW'(gx) + IW'(e_a));
  assign s_idx = IW'(IW'(i_r) * IW'(gx) + IW'(j_r));

  // Neighborhood bounds, clipped to the subtile grid.
  always_comb begin
    x0c = (e_a == '0) ? '0 : GXW'(GXW'({e_a, 1'b0}) - 1'b1);
    y0c = (e_b == '0) ? '0 : GYW'(GYW'({e_b, 1'b0}) - 1'b1);
    x1t = GXW1'(GXW1'({e_a, 1'b0}) + 3);
    y1t = GYW1'(GYW1'({e_b, 1'b0}) + 3);
  end

  always_comb begin
    base   = valid_r[gaddr_r] ? rdata_r : {4{LANE_RESET}};
    lane_v = base[16*lane_r +: 16];
    l_min  = lane_v[7:0];
    l_max  = lane_v[15:8];
    wword  = base;
    wword[16*lane_r +: 16] = {(e_pix > l_max) ? e_pix : l_max,
                              (e_pix < l_min) ? e_pix : l_min};
    thr = ((mx_r > mn_r) && ((mx_r - mn_r) > cfg.contrast_limit)) ?
          8'((9'(mn_r) + 9'(mx_r)) >> 1) : 8'hFF;
  end

  always_comb begin
    st_nxt = st_r;
    rd_en  = 1'b0;
    raddr  = GAW'(g_idx >> 2);
    q_pop  = 1'b0;
    case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data[QW-1] == CMD_GATHER) st_nxt = q_data[QW-2] ? B_GRD : B_IDLE;
          else                            st_nxt = q_data[QW-4] ? B_RES : B_TINI;
        end
      end
      B_GRD: begin
        rd_en  = 1'b1;
        st_nxt = B_GWR;
      end
      B_GWR:  st_nxt = B_IDLE;
      B_TINI: st_nxt = B_TRD;
      B_TRD: begin
        rd_en  = 1'b1;
        raddr  = GAW'(s_idx >> 2);
        st_nxt = B_TACC;
      end
      B_TACC: begin
        if (GXW1'(j_r) + 1'b1 < GXW1'(x1_r))      st_nxt = B_TRD;
        else if (GYW1'(i_r) + 1'b1 < GYW1'(y1_r)) st_nxt = B_TRD;
        else                                      st_nxt = B_TFIN;
      end
      B_TFIN: st_nxt = B_RES;
      B_RES:  if (!out_tvalid_r || out_tready) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[raddr];
    if (st_r == B_GWR) mem[gaddr_r] <= wword;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= B_IDLE;
      valid_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (q_pop && q_data[QW-1] == CMD_GATHER && q_data[QW-3]) valid_r <= '0;
      else if (st_r == B_GWR) valid_r[gaddr_r] <= 1'b1;
      if (st_r == B_RES && (!out_tvalid_r || out_tready)) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_data;
      res_r <= q_data[QW-5 -: 8];
    end
    if (rd_en) begin
      gaddr_r <= raddr;
      lane_r  <= (st_r == B_TRD) ? s_idx[1:0] : g_idx[1:0];
    end
    case (st_r)
      B_TINI: begin
        j_r  <= x0c;
        x0_r <= x0c;
        i_r  <= y0c;
        x1_r <= (x1t > GXW1'(gx)) ? gx : GXW'(x1t);
        y1_r <= (y1t > GYW1'(gy)) ? gy : GYW'(y1t);
        mn_r <= 8'hFF;
        mx_r <= 8'h00;
      end
      B_TACC: begin
        if (l_min < mn_r) mn_r <= l_min;
        if (l_max > mx_r) mx_r <= l_max;
        if (GXW1'(j_r) + 1'b1 < GXW1'(x1_r)) begin
          j_r <= j_r + 1'b1;
        end else begin
          j_r <= x0_r;
          i_r <= i_r + 1'b1;
        end
      end
      B_TFIN: res_r <= (e_pix > thr) ? 8'hFF : 8'h00;
      B_RES:  if (!out_tvalid_r || out_tready) out_tdata_r <= res_r;
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[rtl/tiled_bernsen_threshold.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_bernsen_threshold: two-pass local binarizer for 8-bit gray frames
// A gather pass collects subtile min/max; a threshold pass binarizes pixels
// against the midpoint of their tile's 4x4 subtile neighborhood.
// ----------------------------------------------------------------------------
// Usage: send the frame once with cmd (in_tuser[0]) low to gather statistics,
// setting frame_start (in_tuser[1]) on the first word to clear the store, then
// send it again with cmd high. Each threshold word returns one out_tdata word,
// 255 or 0, or the pixel unchanged outside whole tiles; gather words return
// nothing. Words are taken on the slave side when in_tvalid and in_tready are
// high. The front decodes one word at a time with a shared restoring divider:
// a gather word inside the image needs two divisions in the front, a
// threshold word up to four, and the back then reads the statistics memory
// once per neighborhood subtile (at most 16), one subtile at a time.
// A two-entry queue lets the front take new words while the back is busy.
// Reset restores the register defaults and marks every statistics entry as
// empty at once through per-group valid bits; no clearing pass is needed.
// When out_tready is low the result waits in the output register, the back
// stalls, the queue fills and finally in_tready drops.
// ----------------------------------------------------------------------------
module tiled_bernsen_threshold #(
  parameter int MAX_TILES_X = 16,
  parameter int MAX_TILES_Y = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // pixel[7:0], col[18:8], row[29:19]
  input  logic [1:0]                  in_tuser,   // cmd[0], frame_start[1]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // out_pixel[7:0]
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [tbt_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [tbt_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [tbt_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import tbt_pkg::*;

  // Subtile and tile coordinates share one width per axis.
  localparam int SXW = $clog2(2 * MAX_TILES_X);
  localparam int SYW = $clog2(2 * MAX_TILES_Y);
  localparam int QW  = 12 + SXW + SYW;

  tbt_cfg_t      cfg_r;
  logic          wr_en;
  logic [2:0]    reg_idx;
  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // Register file; writes to addresses beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width    <= 12'd640;
      cfg_r.image_height   <= 12'd480;
      cfg_r.tiles_across   <= 5'd16;
      cfg_r.tiles_down     <= 5'd16;
      cfg_r.contrast_limit <= 8'd10;
    end else if (wr_en) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:    cfg_r.image_width    <= cfg_pwdata[11:0];
        REG_IMAGE_HEIGHT:   cfg_r.image_height   <= cfg_pwdata[11:0];
        REG_TILES_ACROSS:   cfg_r.tiles_across   <= cfg_pwdata[4:0];
        REG_TILES_DOWN:     cfg_r.tiles_down     <= cfg_pwdata[4:0];
        REG_CONTRAST_LIMIT: cfg_r.contrast_limit <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:    cfg_prdata = CFG_DW'(cfg_r.image_width);
      REG_IMAGE_HEIGHT:   cfg_prdata = CFG_DW'(cfg_r.image_height);
      REG_TILES_ACROSS:   cfg_prdata = CFG_DW'(cfg_r.tiles_across);
      REG_TILES_DOWN:     cfg_prdata = CFG_DW'(cfg_r.tiles_down);
      REG_CONTRAST_LIMIT: cfg_prdata = CFG_DW'(cfg_r.contrast_limit);
      default:            cfg_prdata = '0;
    endcase
  end

  tbt_front #(
    .MAX_TILES_X (MAX_TILES_X),
    .MAX_TILES_Y (MAX_TILES_Y),
    .SXW         (SXW),
    .SYW         (SYW),
    .QW          (QW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  tbt_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  tbt_back #(
    .MAX_TILES_X (MAX_TILES_X),
    .MAX_TILES_Y (MAX_TILES_Y),
    .SXW         (SXW),
    .SYW         (SYW),
    .QW          (QW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_data     (q_rdata),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[tb/sv/tiled_bernsen_threshold_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiled_bernsen_threshold_test: self-checking bench for the Bernsen binarizer
// A short table of directed words is followed by randomized frames: each frame
// is a gather pass that usually starts with a frame-start word and then a threshold
// pass, mixed with some out-of-range noise. Every word is run through a local
// model of the subtile statistics. Each output word is compared with the
// oldest predicted pixel. Several register settings are used, the extremes
// among them, and both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tiled_bernsen_threshold_test;
  import tbt_pkg::*;

  localparam int TILES_X   = 16;
  localparam int TILES_Y   = 16;
  localparam int DEPTH     = 4 * TILES_X * TILES_Y;
  // Quiet time after the last predicted pixel, so that any gather word still
  // in flight can settle in the statistics store.
  localparam int DRAIN_CYC = 300;
  localparam int ITEM_GOAL = 1050;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // pixel[7:0], col[18:8], row[29:19]
  logic [1:0]  in_tuser;   // cmd[0], frame_start[1]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // out_pixel[7:0]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic        cfg_pready;

  tiled_bernsen_threshold uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Local copy of the register file and of the subtile statistics.
  logic [11:0] img_w, img_h;
  logic [4:0]  tiles_x_reg, tiles_y_reg;
  logic [7:0]  contrast;
  logic [7:0]  stat_min [DEPTH];
  logic [7:0]  stat_max [DEPTH];

  // Predicted output pixels, oldest first.
  logic [7:0] pixel_queue [$];

  int errors;
  int results_seen;
  int gathers_sent;
  int thresholds_sent;
  int burst_left;
  bit in_burst_mode;

  // One row of the directed table. When known is set, the expected pixel is
  // the typed value instead of the prediction.
  typedef struct {
    logic       cmd;
    logic [7:0] pix;
    logic [10:0] col;
    logic [10:0] row;
    logic       fs;
    bit         known;
    logic [7:0] want;
  } word_row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous watchdog; the slowest legal run stays well below it.
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  function automatic int eff_count(input logic [4:0] t, input int lim);
    if (t == 0) return 1;
    if (t > lim) return lim;
    return t;
  endfunction

  function automatic void clear_stats();
    for (int i = 0; i < DEPTH; i++) begin
      stat_min[i] = 8'hFF;
      stat_max[i] = 8'h00;
    end
  endfunction

  // Applies one accepted word to the statistics and, for a threshold word,
  // returns the binarized pixel.
  function automatic bit binarize_word(input logic cmd, input logic [7:0] pix,
                                       input logic [10:0] col, input logic [10:0] row,
                                       input logic fs, output logic [7:0] res);
    int nx, ny, gx, gy, sx, sy, idx, tw, th, tx, ty, x0, x1, y0, y1;
    int mn, mx, thr;
    nx = eff_count(tiles_x_reg, TILES_X);
    ny = eff_count(tiles_y_reg, TILES_Y);
    gx = 2 * nx;
    gy = 2 * ny;
    res = 8'h00;
    if (cmd == CMD_GATHER) begin
      if (fs) clear_stats();
      if (col < img_w && row < img_h) begin
        sx = ((col + 1) * gx - 1) / img_w;
        sy = ((row + 1) * gy - 1) / img_h;
        idx = sy * gx + sx;
        if (idx < DEPTH) begin
          if (pix < stat_min[idx]) stat_min[idx] = pix;
          if (pix > stat_max[idx]) stat_max[idx] = pix;
        end
      end
      return 1'b0;
    end
    tw = img_w / nx;
    th = img_h / ny;
    // Outside whole tiles the pixel passes through untouched.
    if (tw == 0 || th == 0 || col >= tw * nx || row >= th * ny) begin
      res = pix;
      return 1'b1;
    end
    tx = col / tw;
    ty = row / th;
    x0 = (tx == 0) ? 0 : 2 * tx - 1;
    y0 = (ty == 0) ? 0 : 2 * ty - 1;
    x1 = (2 * tx + 3 > gx) ? gx : 2 * tx + 3;
    y1 = (2 * ty + 3 > gy) ? gy : 2 * ty + 3;
    mn = 255;
    mx = 0;
    for (int i = y0; i < y1; i++) begin
      for (int j = x0; j < x1; j++) begin
        idx = i * gx + j;
        if (idx < DEPTH) begin
          if (stat_min[idx] < mn) mn = stat_min[idx];
          if (stat_max[idx] > mx) mx = stat_max[idx];
        end
      end
    end
    thr = (mx > mn && mx - mn > contrast) ? (mn + mx) / 2 : 255;
    res = (pix > thr) ? 8'd255 : 8'd0;
    return 1'b1;
  endfunction

  // Drives one word and waits for it to be taken. The sender runs in bursts:
  // when a burst is used up it idles for a random gap before the next one.
  task automatic send_word(input logic cmd, input logic [7:0] pix,
                           input logic [10:0] col, input logic [10:0] row,
                           input logic fs, input bit known, input logic [7:0] want);
    logic [7:0] res;
    bit has_res;
    int gap;
    if (burst_left == 0) begin
      gap = in_burst_mode ? $urandom_range(1, 3) : $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, row, col, pix};
    in_tuser  <= {fs, cmd};
    // Inputs only move at rising edges, so the ready seen at the falling edge
    // is the one sampled at the next rising edge.
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    has_res = binarize_word(cmd, pix, col, row, fs, res);
    if (cmd == CMD_GATHER) gathers_sent++;
    else thresholds_sent++;
    if (has_res) pixel_queue.push_back(known ? want : res);
  endtask

  // Lowers valid and waits until every predicted pixel has arrived, then lets
  // any gather word still in the pipeline settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // Two-phase register write; the register takes the value at the access edge.
  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({index, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (index)
      REG_IMAGE_WIDTH:    img_w       = value[11:0];
      REG_IMAGE_HEIGHT:   img_h       = value[11:0];
      REG_TILES_ACROSS:   tiles_x_reg = value[4:0];
      REG_TILES_DOWN:     tiles_y_reg = value[4:0];
      REG_CONTRAST_LIMIT: contrast    = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input logic [11:0] w, input logic [11:0] h,
                          input logic [4:0] tx, input logic [4:0] ty,
                          input logic [7:0] lim);
    write_reg(REG_IMAGE_WIDTH, {20'd0, w});
    write_reg(REG_IMAGE_HEIGHT, {20'd0, h});
    write_reg(REG_TILES_ACROSS, {27'd0, tx});
    write_reg(REG_TILES_DOWN, {27'd0, ty});
    write_reg(REG_CONTRAST_LIMIT, {24'd0, lim});
  endtask

  // Random position inside the configured extent, or anywhere if it is empty.
  function automatic logic [10:0] pos_in(input logic [11:0] len);
    if (len == 0) return 11'($urandom_range(0, 2047));
    return 11'($urandom_range(0, (len > 2048 ? 2048 : len) - 1));
  endfunction

  // The receiver changes its stall habit periodically: always ready,
  // occasional stalls, or long stretches of backpressure.
  int stall_mode;
  int stall_cnt;
  always @(posedge clk) begin
    if (stall_cnt == 0) stall_mode <= $urandom_range(0, 2);
    stall_cnt <= (stall_cnt == 199) ? 0 : stall_cnt + 1;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Output checker: a word is taken at the rising edge after a falling edge
  // that sees valid and ready both high.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pixel_queue.size() == 0) begin
        $error("out_pixel: unexpected word, actual %0d", out_tdata);
        errors++;
      end else begin
        if (out_tdata !== pixel_queue[0]) begin
          $error("out_pixel: expected %0d, actual %0d", pixel_queue[0], out_tdata);
          errors++;
        end
        void'(pixel_queue.pop_front());
      end
    end
  end

  initial begin
    word_row_t table_rows [$];
    word_row_t r;
    int n_items;
    int phase;
    int n_gather;
    int n_thr;
    logic [11:0] w, h;
    logic [4:0]  tx, ty;
    logic [7:0]  lim;

    errors = 0;
    results_seen = 0;
    gathers_sent = 0;
    thresholds_sent = 0;
    burst_left = 0;
    in_burst_mode = 0;
    stall_cnt = 0;
    stall_mode = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b1;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    img_w = 12'd640;
    img_h = 12'd480;
    tiles_x_reg = 5'd16;
    tiles_y_reg = 5'd16;
    contrast = 8'd10;
    clear_stats();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words against the reset settings: 640x480 with 16x16 tiles of
    // 40x30 pixels. Subtile (0,0) covers columns 0..19 and rows 0..14.
    //                 cmd            pix    col    row    fs    known want
    table_rows.push_back('{CMD_THRESHOLD, 8'hFF, 11'd0, 11'd0, 1'b0, 1, 8'd0});
    table_rows.push_back('{CMD_THRESHOLD, 8'h5A, 11'd640, 11'd5, 1'b0, 1, 8'h5A});
    table_rows.push_back('{CMD_THRESHOLD, 8'hA5, 11'd2047, 11'd2047, 1'b0, 1, 8'hA5});
    table_rows.push_back('{CMD_THRESHOLD, 8'h33, 11'd3, 11'd480, 1'b0, 1, 8'h33});
    table_rows.push_back('{CMD_GATHER, 8'h00, 11'd0, 11'd0, 1'b1, 0, 8'd0});
    table_rows.push_back('{CMD_GATHER, 8'hFF, 11'd10, 11'd10, 1'b0, 0, 8'd0});
    table_rows.push_back('{CMD_GATHER, 8'h80, 11'd700, 11'd10, 1'b0, 0, 8'd0});
    table_rows.push_back('{CMD_THRESHOLD, 8'd128, 11'd0, 11'd0, 1'b0, 0, 8'd0});
    table_rows.push_back('{CMD_THRESHOLD, 8'd127, 11'd39, 11'd29, 1'b0, 0, 8'd0});
    table_rows.push_back('{CMD_THRESHOLD, 8'd200, 11'd45, 11'd35, 1'b1, 0, 8'd0});
    table_rows.push_back('{CMD_THRESHOLD, 8'd200, 11'd639, 11'd479, 1'b0, 0, 8'd0});
    // A frame start outside the image still clears the statistics.
    table_rows.push_back('{CMD_GATHER, 8'h07, 11'd2047, 11'd2047, 1'b1, 0, 8'd0});
    table_rows.push_back('{CMD_THRESHOLD, 8'hFF, 11'd0, 11'd0, 1'b0, 1, 8'd0});
    // Spread of 5 is under the contrast limit, so the threshold stays 255.
    table_rows.push_back('{CMD_GATHER, 8'd100, 11'd600, 11'd470, 1'b0, 0, 8'd0});
    table_rows.push_back('{CMD_GATHER, 8'd105, 11'd639, 11'd479, 1'b0, 0, 8'd0});
    table_rows.push_back('{CMD_THRESHOLD, 8'd103, 11'd639, 11'd479, 1'b0, 1, 8'd0});
    table_rows.push_back('{CMD_THRESHOLD, 8'hFF, 11'd320, 11'd240, 1'b0, 1, 8'd0});
    table_rows.push_back('{CMD_GATHER, 8'hFF, 11'd321, 11'd241, 1'b0, 0, 8'd0});
    table_rows.push_back('{CMD_GATHER, 8'h00, 11'd300, 11'd220, 1'b0, 0, 8'd0});
    table_rows.push_back('{CMD_THRESHOLD, 8'd128, 11'd320, 11'd240, 1'b0, 0, 8'd0});
    table_rows.push_back('{CMD_THRESHOLD, 8'd127, 11'd300, 11'd230, 1'b0, 0, 8'd0});

    foreach (table_rows[i]) begin
      r = table_rows[i];
      send_word(r.cmd, r.pix, r.col, r.row, r.fs, r.known, r.want);
    end
    n_items = table_rows.size();

    // Randomized frames. Each phase starts from an idle block with a new
    // setting; phases 0 to 4 pin extreme values of the registers.
    phase = 0;
    while (n_items < ITEM_GOAL) begin
      drain();
      case (phase)
        0: begin w = 12'd2048; h = 12'd2048; tx = 5'd16; ty = 5'd16; lim = 8'd0; end
        1: begin w = 12'd1;    h = 12'd1;    tx = 5'd1;  ty = 5'd1;  lim = 8'd255; end
        2: begin w = 12'd4095; h = 12'd7;    tx = 5'd0;  ty = 5'd31; lim = 8'd10; end
        3: begin w = 12'd0;    h = 12'd0;    tx = 5'd31; ty = 5'd0;  lim = 8'd128; end
        4: begin w = 12'd33;   h = 12'd17;   tx = 5'd16; ty = 5'd16; lim = 8'd0; end
        default: begin
          w   = ($urandom_range(0, 2) == 0) ? 12'($urandom_range(1, 4095))
                                            : 12'($urandom_range(1, 96));
          h   = ($urandom_range(0, 2) == 0) ? 12'($urandom_range(1, 4095))
                                            : 12'($urandom_range(1, 96));
          tx  = 5'($urandom_range(0, 31));
          ty  = 5'($urandom_range(0, 31));
          lim = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 40));
        end
      endcase
      set_grid(w, h, tx, ty, lim);
      in_burst_mode = $urandom_range(0, 1);

      // Gather pass; most frames clear the store on their first word, the
      // rest reuse statistics indexed with the new grid.
      n_gather = $urandom_range(30, 80);
      for (int k = 0; k < n_gather; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_word(CMD_GATHER, 8'($urandom), 11'($urandom), 11'($urandom),
                    1'($urandom), 0, 8'd0);
        else
          send_word(CMD_GATHER, 8'($urandom), pos_in(img_w), pos_in(img_h),
                    (k == 0) && ($urandom_range(0, 4) != 0), 0, 8'd0);
      end

      // Threshold pass with a few words anywhere in the coordinate space.
      n_thr = $urandom_range(40, 80);
      for (int k = 0; k < n_thr; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_word(CMD_THRESHOLD, 8'($urandom), 11'($urandom), 11'($urandom),
                    1'($urandom), 0, 8'd0);
        else
          send_word(CMD_THRESHOLD, 8'($urandom), pos_in(img_w), pos_in(img_h),
                    1'b0, 0, 8'd0);
      end
      n_items += n_gather + n_thr;
      phase++;
    end

    drain();

    $display("Covered %0d gather and %0d threshold words over %0d register settings,",
             gathers_sent, thresholds_sent, phase + 1);
    $display("with %0d output words checked and %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/tbt_pkg.sv
rtl/tbt_div.sv
rtl/tbt_queue.sv
rtl/tbt_front.sv
rtl/tbt_back.sv
rtl/tiled_bernsen_threshold.sv
tb/sv/tiled_bernsen_threshold_test.sv
